[src/wann_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the wrapped-angle nearest-neighbor store.
// Used by the top level, wann_lane and wann_merge; depends on nothing.
package wann_pkg;

  // Angle format: signed radians scaled by 2^(ANGLE_BITS-3).
  localparam int ANGLE_BITS  = 16;
  localparam int JOINT_COUNT = 6;
  localparam int FRAC_BITS   = ANGLE_BITS - 3;
  localparam int BANK_SIZE   = 64;
  localparam int BANK_BITS   = 6;

  // Pi rounded to the angle scale, derived from a Q30 value.
  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam int          PI_SHIFT = 30 - FRAC_BITS;
  localparam int          DIFF_W   = ANGLE_BITS + 2;
  localparam logic signed [DIFF_W-1:0] PI_FIX =
    DIFF_W'((PI_Q30 + (64'd1 << (PI_SHIFT - 1))) >> PI_SHIFT);
  localparam logic signed [DIFF_W-1:0] TWO_PI_FIX = DIFF_W'(2 * PI_FIX);

  // Square of one folded difference and the sum over all joints.
  localparam int SQ_W   = 2 * ANGLE_BITS;
  localparam int SUM_W  = SQ_W + 3;
  localparam int DIST_W = 32;
  localparam int RAD_W  = 16;

  // Operation codes.
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_NEAREST = 2'd1;
  localparam logic [1:0] OP_RADIUS  = 2'd2;

  // Tag that travels with each node through the scan pipeline.
  typedef struct packed {
    logic vld;
    logic first;
  } scan_tag_t;

endpackage

[src/wrapped_angle_nearest_neighbor.sv]
`timescale 1ns / 1ps
// Top level of the wrapped-angle nearest-neighbor store.
// Depends on wann_pkg, wann_ram, wann_lane and wann_merge.
//
// An add beat returns the new node index, or flags a full store. A nearest
// or radius beat scans the stored nodes at one node per cycle, limited by the
// single read port of the node memory; six joint lanes fold and square the
// differences in parallel and a merge stage sums them. A nearest query scans
// all stored nodes, then drains the pipeline; a radius query scans each bank
// of 64 nodes in turn, drains the pipeline and emits the bank's beat. One
// item is worked at a time; the output register lets the next item start
// while the last result waits to be taken.
module wrapped_angle_nearest_neighbor #(
  parameter int NODE_CAPACITY = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_opcode,
  input  logic signed [wann_pkg::ANGLE_BITS-1:0] in_joint_0,
  input  logic signed [wann_pkg::ANGLE_BITS-1:0] in_joint_1,
  input  logic signed [wann_pkg::ANGLE_BITS-1:0] in_joint_2,
  input  logic signed [wann_pkg::ANGLE_BITS-1:0] in_joint_3,
  input  logic signed [wann_pkg::ANGLE_BITS-1:0] in_joint_4,
  input  logic signed [wann_pkg::ANGLE_BITS-1:0] in_joint_5,
  input  logic [wann_pkg::RAD_W-1:0]             in_search_radius,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [9:0]                             out_node_index,
  output logic [wann_pkg::DIST_W-1:0]            out_best_dist_sq,
  output logic [3:0]                             out_bank,
  output logic [wann_pkg::BANK_SIZE-1:0]         out_match_mask,
  output logic                                   out_store_full,
  output logic                                   out_tree_empty,
  output logic                                   out_last
);
  import wann_pkg::*;

  localparam int CNT_W  = $clog2(NODE_CAPACITY + 1);
  localparam int IDX_W  = $clog2(NODE_CAPACITY);
  localparam int WORD_W = JOINT_COUNT * ANGLE_BITS;
  localparam logic [CNT_W:0] CAP_X = (CNT_W + 1)'(NODE_CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} state_t;

  state_t                        state_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [1:0]                    op_r;
  logic signed [ANGLE_BITS-1:0]  q_r [JOINT_COUNT];
  logic [2*RAD_W-1:0]            r2_r;
  logic [CNT_W-1:0]              ptr_r;
  logic [CNT_W-1:0]              hi_r;
  logic [CNT_W-BANK_BITS-1:0]    bank_r;
  logic                          first_r;
  logic                          res_full_r;
  logic                          res_empty_r;
  logic [IDX_W-1:0]              res_idx_r;

  logic                          out_valid_r;
  logic [9:0]                    out_idx_r;
  logic [DIST_W-1:0]             out_dist_r;
  logic [3:0]                    out_bank_r;
  logic [BANK_SIZE-1:0]          out_mask_r;
  logic                          out_full_r;
  logic                          out_empty_r;
  logic                          out_last_r;

  logic                          accept;
  logic                          emit_go;
  logic                          ram_we;
  logic [WORD_W-1:0]             ram_wdata;
  logic [WORD_W-1:0]             ram_rdata;
  scan_tag_t                     iss_tag;
  scan_tag_t                     t1_r, t2_r, t3_r;
  logic [IDX_W-1:0]              idx1_r, idx2_r, idx3_r;
  logic [SQ_W-1:0]               sq [JOINT_COUNT];
  logic [SUM_W-1:0]              best_d;
  logic [IDX_W-1:0]              best_idx;
  logic [BANK_SIZE-1:0]          mask;
  logic                          merge_busy;
  logic                          drained;
  logic [CNT_W:0]                hi_step;
  logic [CNT_W:0]                hi_first;
  logic                          bank_last;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign ram_we    = accept && (in_opcode == OP_ADD) && (cnt_r < CNT_W'(NODE_CAPACITY));
  assign ram_wdata = {in_joint_5, in_joint_4, in_joint_3, in_joint_2, in_joint_1, in_joint_0};

  // Node memory: one row holds all joints of a node.
  wann_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NODE_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ptr_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // One lane per joint.
  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_lane
    wann_lane u_lane (
      .clk      (clk),
      .node_ang (ram_rdata[j*ANGLE_BITS +: ANGLE_BITS]),
      .qry_ang  (q_r[j]),
      .sq       (sq[j])
    );
  end

  wann_merge #(
    .IDX_W (IDX_W)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_i    (t3_r),
    .idx_i    (idx3_r),
    .sq_i     (sq),
    .r2_i     (r2_r),
    .best_d   (best_d),
    .best_idx (best_idx),
    .mask     (mask),
    .busy     (merge_busy)
  );

  // Tag pipeline alongside the memory read and the two lane stages.
  assign iss_tag.vld   = (state_r == S_SCAN);
  assign iss_tag.first = first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
    end else begin
      t1_r <= iss_tag;
      t2_r <= t1_r;
      t3_r <= t2_r;
    end
    idx1_r <= ptr_r[IDX_W-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
  end

  assign drained   = !t1_r.vld && !t2_r.vld && !t3_r.vld && !merge_busy;
  assign hi_step   = (CNT_W + 1)'(hi_r) + (CNT_W + 1)'(BANK_SIZE);
  assign hi_first  = ((CNT_W + 1)'(cnt_r) < (CNT_W + 1)'(BANK_SIZE)) ?
                     (CNT_W + 1)'(cnt_r) : (CNT_W + 1)'(BANK_SIZE);
  assign bank_last = (hi_r >= cnt_r);

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r        <= in_opcode;
            q_r[0]      <= in_joint_0;
            q_r[1]      <= in_joint_1;
            q_r[2]      <= in_joint_2;
            q_r[3]      <= in_joint_3;
            q_r[4]      <= in_joint_4;
            q_r[5]      <= in_joint_5;
            r2_r        <= (2*RAD_W)'(in_search_radius) * (2*RAD_W)'(in_search_radius);
            ptr_r       <= '0;
            bank_r      <= '0;
            first_r     <= 1'b1;
            res_full_r  <= (in_opcode == OP_ADD) && !ram_we;
            res_empty_r <= (cnt_r == '0);
            res_idx_r   <= cnt_r[IDX_W-1:0];
            hi_r        <= (in_opcode == OP_RADIUS) ? CNT_W'(hi_first) : cnt_r;
            if (in_opcode == OP_ADD) begin
              if (ram_we) begin
                cnt_r <= cnt_r + 1'b1;
              end
              state_r <= S_EMIT;
            end else if (in_opcode == OP_NEAREST || in_opcode == OP_RADIUS) begin
              state_r <= (cnt_r == '0) ? S_EMIT : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          ptr_r   <= ptr_r + 1'b1;
          first_r <= 1'b0;
          if (ptr_r + 1'b1 == hi_r) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drained) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            priority if (op_r == OP_ADD) begin
              out_idx_r   <= res_full_r ? 10'd0 : 10'(res_idx_r);
              out_dist_r  <= '0;
              out_bank_r  <= '0;
              out_mask_r  <= '0;
              out_full_r  <= res_full_r;
              out_empty_r <= 1'b0;
              out_last_r  <= 1'b1;
              state_r     <= S_IDLE;
            end else if (op_r == OP_NEAREST) begin
              // An empty store reports infinity; a real sum saturates at 32 bits.
              out_idx_r   <= res_empty_r ? 10'd0 : 10'(best_idx);
              out_dist_r  <= (res_empty_r || best_d > SUM_W'({DIST_W{1'b1}})) ?
                             {DIST_W{1'b1}} : DIST_W'(best_d);
              out_bank_r  <= '0;
              out_mask_r  <= '0;
              out_full_r  <= 1'b0;
              out_empty_r <= res_empty_r;
              out_last_r  <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              out_idx_r   <= '0;
              out_dist_r  <= '0;
              out_bank_r  <= 4'(bank_r);
              out_mask_r  <= res_empty_r ? '0 : mask;
              out_full_r  <= 1'b0;
              out_empty_r <= 1'b0;
              out_last_r  <= res_empty_r || bank_last;
              if (!res_empty_r && !bank_last) begin
                bank_r  <= bank_r + 1'b1;
                first_r <= 1'b1;
                hi_r    <= (hi_step < (CNT_W + 1)'(cnt_r)) ? CNT_W'(hi_step) : cnt_r;
                state_r <= S_SCAN;
              end else begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_node_index   = out_idx_r;
  assign out_best_dist_sq = out_dist_r;
  assign out_bank         = out_bank_r;
  assign out_match_mask   = out_mask_r;
  assign out_store_full   = out_full_r;
  assign out_tree_empty   = out_empty_r;
  assign out_last         = out_last_r;

  // The node count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W + 1)'(cnt_r) <= CAP_X)
    else $error("node count exceeds capacity");

  // A scan never issues past the end of its range.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (ptr_r < hi_r))
    else $error("scan pointer out of range");

  // No node is in flight while the block waits for a new beat.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!t1_r.vld && !t2_r.vld && !t3_r.vld && !merge_busy))
    else $error("scan pipeline busy while idle");

  // A dropped add is only reported with a full store.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (cnt_r == CNT_W'(NODE_CAPACITY)))
    else $error("store full reported below capacity");

endmodule

[src/wann_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module wann_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/wann_lane.sv]
`timescale 1ns / 1ps
// One joint lane: difference folded into [-pi, pi], then squared.
// Depends on wann_pkg. Two register stages.
module wann_lane (
  input  logic                                   clk,
  input  logic signed [wann_pkg::ANGLE_BITS-1:0] node_ang,
  input  logic signed [wann_pkg::ANGLE_BITS-1:0] qry_ang,
  output logic [wann_pkg::SQ_W-1:0]              sq
);
  import wann_pkg::*;

  logic signed [DIFF_W-1:0]     diff;
  logic signed [DIFF_W-1:0]     fold;
  logic signed [ANGLE_BITS-1:0] fold_r;
  logic signed [SQ_W-1:0]       fold_ext;
  logic [SQ_W-1:0]              sq_r;

  // A raw difference lies within three pi of zero, so one correction suffices.
  always_comb begin
    diff = DIFF_W'(node_ang) - DIFF_W'(qry_ang);
    if (diff > PI_FIX) begin
      fold = diff - TWO_PI_FIX;
    end else if (diff < -PI_FIX) begin
      fold = diff + TWO_PI_FIX;
    end else begin
      fold = diff;
    end
  end

  assign fold_ext = SQ_W'(fold_r);

  // Fold stage, then square stage.
  always_ff @(posedge clk) begin
    fold_r <= ANGLE_BITS'(fold);
    sq_r   <= SQ_W'(fold_ext * fold_ext);
  end

  assign sq = sq_r;

endmodule

[src/wann_merge.sv]
`timescale 1ns / 1ps
// Merge stage: sums the lane squares and tracks the nearest node or the radius mask.
// Depends on wann_pkg.
module wann_merge #(
  parameter int IDX_W = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wann_pkg::scan_tag_t                   tag_i,
  input  logic [IDX_W-1:0]                      idx_i,
  input  logic [wann_pkg::SQ_W-1:0]             sq_i [wann_pkg::JOINT_COUNT],
  input  logic [2*wann_pkg::RAD_W-1:0]          r2_i,
  output logic [wann_pkg::SUM_W-1:0]            best_d,
  output logic [IDX_W-1:0]                      best_idx,
  output logic [wann_pkg::BANK_SIZE-1:0]        mask,
  output logic                                  busy
);
  import wann_pkg::*;

  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_r;
  scan_tag_t            tag_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 hit;
  logic [SUM_W-1:0]     best_d_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [BANK_SIZE-1:0] mask_r;
  logic [BANK_SIZE-1:0] bit_sel;

  // Add the squares of all joints.
  always_comb begin
    sum = '0;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      sum = sum + SUM_W'(sq_i[j]);
    end
  end

  assign hit     = (sum_r <= SUM_W'(r2_i));
  assign bit_sel = BANK_SIZE'(hit) << idx_r[BANK_BITS-1:0];

  // Sum register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
    sum_r <= sum;
    idx_r <= idx_i;
  end

  // Accumulate: the first node of a scan restarts both the best and the mask.
  always_ff @(posedge clk) begin
    if (tag_r.vld) begin
      if (tag_r.first || sum_r < best_d_r) begin
        best_d_r   <= sum_r;
        best_idx_r <= idx_r;
      end
      if (tag_r.first) begin
        mask_r <= bit_sel;
      end else begin
        mask_r <= mask_r | bit_sel;
      end
    end
  end

  assign best_d   = best_d_r;
  assign best_idx = best_idx_r;
  assign mask     = mask_r;
  assign busy     = tag_r.vld;

endmodule
